FILE: design/huffman_tree_walk_decoder_unit_assert.svh
// Assertion macros used by the Huffman tree walk decoder controller.
`ifndef HUFFMAN_TREE_WALK_DECODER_UNIT_ASSERT_SVH
`define HUFFMAN_TREE_WALK_DECODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTWD_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("htwd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HTWD_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("htwd assertion failed");

`endif

FILE: design/htwd_pkg.sv
// Shared constants, types and controller interface of the Huffman tree walk decoder.
package htwd_pkg;

  // Table and field sizes.
  localparam int MAX_NODES   = 512;
  localparam int ADDR_BITS   = $clog2(MAX_NODES);
  localparam int NODE_BITS   = 9;
  localparam int SYMBOL_BITS = 8;

  // Operation codes of an input transaction.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // One node of the tree table.
  typedef struct packed {
    logic [NODE_BITS-1:0]   left;
    logic [NODE_BITS-1:0]   right;
    logic [SYMBOL_BITS-1:0] sym;
  } node_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NODE,
    ST_CHILD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_node;
    logic rd_node;
    logic rd_child;
    logic step;
    logic go_root;
    logic load_out;
    logic out_bad;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_decode;
    logic child_ok;
    logic child_leaf;
    logic out_free;
  } ctrl_status_t;

endpackage

FILE: design/htwd_ctrl.sv
// Controller state machine that sequences node writes and tree walk steps.
`include "huffman_tree_walk_decoder_unit_assert.svh"

module htwd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  htwd_pkg::ctrl_status_t stat,
  output htwd_pkg::ctrl_cmd_t    cmd
);

  htwd_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= htwd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      htwd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (stat.in_decode) begin
            cmd.rd_node = 1'b1;
            state_next  = htwd_pkg::ST_NODE;
          end else begin
            cmd.wr_node = 1'b1;
          end
        end
      end
      htwd_pkg::ST_NODE: begin
        // The current node is in hand; follow the selected link or flag it.
        if (stat.child_ok) begin
          cmd.rd_child = 1'b1;
          state_next   = htwd_pkg::ST_CHILD;
        end else if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_bad  = 1'b1;
          cmd.go_root  = 1'b1;
          state_next   = htwd_pkg::ST_IDLE;
        end
      end
      htwd_pkg::ST_CHILD: begin
        // The child is in hand; emit its symbol on a leaf or move onto it.
        if (!stat.child_leaf) begin
          cmd.step   = 1'b1;
          state_next = htwd_pkg::ST_IDLE;
        end else if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.go_root  = 1'b1;
          state_next   = htwd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = htwd_pkg::ST_IDLE;
      end
    endcase
  end

  // A result is only loaded into a free output register.
  `HTWD_ASSERT_SAME(a_load_free, clk, rst, cmd.load_out, stat.out_free)
  // An accepted decode transaction always starts with the node read.
  `HTWD_ASSERT_NEXT(a_decode_start, clk, rst,
    in_valid && !in_stall && stat.in_decode, state == htwd_pkg::ST_NODE)
  // The child read is only reached from the node read.
  `HTWD_ASSERT_NEXT(a_child_order, clk, rst, state_next == htwd_pkg::ST_CHILD,
    $past(state) == htwd_pkg::ST_NODE || $past(state) == htwd_pkg::ST_CHILD)

endmodule

FILE: design/htwd_datapath.sv
// Datapath with the node table memory, walk position, root register and output register.
module htwd_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                op,
  input  logic [htwd_pkg::NODE_BITS-1:0]      node_index,
  input  logic [htwd_pkg::NODE_BITS-1:0]      left_child,
  input  logic [htwd_pkg::NODE_BITS-1:0]      right_child,
  input  logic [htwd_pkg::SYMBOL_BITS-1:0]    leaf_symbol,
  input  logic                                code_bit,
  input  logic                                cfg_write,
  input  logic [htwd_pkg::NODE_BITS-1:0]      cfg_data,
  input  htwd_pkg::ctrl_cmd_t                  cmd,
  output htwd_pkg::ctrl_status_t               stat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [htwd_pkg::SYMBOL_BITS-1:0]    symbol,
  output logic                                bad_link
);

  htwd_pkg::node_t mem [htwd_pkg::MAX_NODES];
  htwd_pkg::node_t rd_data;

  logic [htwd_pkg::NODE_BITS-1:0] root;
  logic [htwd_pkg::NODE_BITS-1:0] pos;
  logic [htwd_pkg::NODE_BITS-1:0] child;
  logic                           code_q;
  logic                           nil_q;

  logic [htwd_pkg::NODE_BITS-1:0] left_eff;
  logic [htwd_pkg::NODE_BITS-1:0] right_eff;
  logic [htwd_pkg::NODE_BITS-1:0] child_sel;
  logic [htwd_pkg::ADDR_BITS-1:0] rd_addr;
  logic                           pos_nil;
  logic                           wr_ok;

  // Link selection and checks. Entry zero and positions beyond the table read as no links.
  always_comb begin
    left_eff  = nil_q ? '0 : rd_data.left;
    right_eff = nil_q ? '0 : rd_data.right;
    child_sel = code_q ? right_eff : left_eff;
    pos_nil   = (pos == '0) || (32'(pos) >= htwd_pkg::MAX_NODES);
    wr_ok     = (node_index != '0) && (32'(node_index) < htwd_pkg::MAX_NODES);
    rd_addr   = cmd.rd_node ? pos[htwd_pkg::ADDR_BITS-1:0]
                            : child_sel[htwd_pkg::ADDR_BITS-1:0];
  end

  // Status toward the controller.
  always_comb begin
    stat.in_decode  = (op == htwd_pkg::OP_DECODE);
    stat.child_ok   = (child_sel != '0) && (child_sel <= root) &&
                      (32'(child_sel) < htwd_pkg::MAX_NODES);
    stat.child_leaf = (rd_data.left == '0) && (rd_data.right == '0);
    stat.out_free   = !out_valid || !out_stall;
  end

  // Node table: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_node && wr_ok) begin
      mem[node_index[htwd_pkg::ADDR_BITS-1:0]] <= '{left:  left_child,
                                                   right: right_child,
                                                   sym:   leaf_symbol};
    end
    if (cmd.rd_node || cmd.rd_child) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Per-step payload held across the walk.
  always_ff @(posedge clk) begin
    if (cmd.rd_node) begin
      code_q <= code_bit;
      nil_q  <= pos_nil;
    end
    if (cmd.rd_child) begin
      child <= child_sel;
    end
  end

  // Root register and walk position.
  always_ff @(posedge clk) begin
    if (rst) begin
      root <= 9'd1;
      pos  <= 9'd1;
    end else if (cfg_write) begin
      root <= cfg_data;
      pos  <= cfg_data;
    end else if (cmd.go_root) begin
      pos <= root;
    end else if (cmd.step) begin
      pos <= child;
    end
  end

  // Output register for one result transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      symbol   <= cmd.out_bad ? '0 : rd_data.sym;
      bad_link <= cmd.out_bad;
    end
  end

endmodule

FILE: design/huffman_tree_walk_decoder_unit.sv
// Top level of the Huffman tree walk decoder. A write transaction (op 0) stores one
// node of the tree table. A decode transaction (op 1) runs in steps: acceptance,
// a read of the current node to pick its child link and, if that link is valid, a
// read of that child to test for a leaf, in turn on the node table's single read port.
// A result appears when a leaf is reached or a link is zero or beyond the root index;
// the walker then returns to the root. The output register lets the next transaction
// be accepted while a result still waits; a new result waits until that register is
// free. Writing cfg_data with cfg_write sets the root index and returns the walker to
// the root. Nodes must be written before the walk reads them.
module huffman_tree_walk_decoder_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [htwd_pkg::NODE_BITS-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             op,
  input  logic [htwd_pkg::NODE_BITS-1:0]   node_index,
  input  logic [htwd_pkg::NODE_BITS-1:0]   left_child,
  input  logic [htwd_pkg::NODE_BITS-1:0]   right_child,
  input  logic [htwd_pkg::SYMBOL_BITS-1:0] leaf_symbol,
  input  logic                             code_bit,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [htwd_pkg::SYMBOL_BITS-1:0] symbol,
  output logic                             bad_link
);

  htwd_pkg::ctrl_cmd_t    cmd;
  htwd_pkg::ctrl_status_t stat;

  // Sequencing of each transaction.
  htwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Table, walker and result storage.
  htwd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .node_index  (node_index),
    .left_child  (left_child),
    .right_child (right_child),
    .leaf_symbol (leaf_symbol),
    .code_bit    (code_bit),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol      (symbol),
    .bad_link    (bad_link)
  );

endmodule
